// ----- src/blm_pkg.sv -----
// Shared types, widths and constants of the battery level monitor.
package blm_pkg;

   // Field and datapath widths
   localparam int MV_W      = 13;
   localparam int SPAN_W    = 10;
   localparam int SPEED_W   = 7;
   localparam int SUM_W     = 20;
   localparam int THR_W     = 15;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = 17;
   localparam int DROP_W    = 10;

   // Fan speed clamp and knee, percent
   localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd100;
   localparam logic [SPEED_W-1:0] SPEED_KNEE = 7'd20;

   // Ceiling division by 80: add 79, shift by 4, then divide by 5 via reciprocal
   localparam logic [PROD_W-1:0] DROP_ROUND   = 17'd79;
   localparam int                DIV16_SHIFT  = 4;
   localparam int                DIV5_IN_W    = PROD_W - DIV16_SHIFT;
   localparam int                DIV5_MUL_W   = 14;
   localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 14'd13108;
   localparam int                DIV5_SHIFT   = 16;
   localparam int                DIV5_PROD_W  = DIV5_IN_W + DIV5_MUL_W;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAULT_TRIP,
      CSR_FAULT_CLEAR,
      CSR_VERY_LOW,
      CSR_BASE_THR,
      CSR_THR_SPAN,
      CSR_HYST
   } blm_csr_index_type;

   // Charge level codes
   typedef enum logic [1:0] {
      LEVEL_PLENTY,
      LEVEL_MID,
      LEVEL_LOW,
      LEVEL_VERY_LOW
   } blm_level_type;

   // Configuration registers
   typedef struct packed {
      logic [MV_W-1:0]   fault_trip;
      logic [MV_W-1:0]   fault_clear;
      logic [MV_W-1:0]   very_low;
      logic [MV_W-1:0]   base_thr;
      logic [SPAN_W-1:0] thr_span;
      logic [SPAN_W-1:0] hyst;
   } blm_cfg_type;

   localparam blm_cfg_type CFG_RESET = '{
      fault_trip:  13'd2820,
      fault_clear: 13'd3000,
      very_low:    13'd2950,
      base_thr:    13'd3700,
      thr_span:    10'd300,
      hyst:        10'd200
   };

   // One request as it enters the decision stage
   typedef struct packed {
      logic                    updated;
      logic [MV_W-1:0]         quot;
      logic signed [THR_W-1:0] thres;
      logic [MV_W-1:0]         mode_thr;
   } blm_step_type;

endpackage

// ----- src/blm_avg.sv -----
// Sample accumulator: running sum, minimum, maximum and count of one averaging window.
module blm_avg #(
   parameter int SAMPLES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [blm_pkg::MV_W-1:0]    sample_mv,
   output logic                        flush,
   output logic [blm_pkg::SUM_W-1:0]   rest
);

   localparam int CNT_W = $clog2(SAMPLES + 1);

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [blm_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [blm_pkg::MV_W-1:0]  min_ff, min_in;
   logic [blm_pkg::MV_W-1:0]  max_ff, max_in;

   // A full window is flushed by the next request; its sample is dropped
   assign flush = (cnt_ff == CNT_W'(SAMPLES));
   assign rest  = sum_ff - blm_pkg::SUM_W'(min_ff) - blm_pkg::SUM_W'(max_ff);

   // Restart, open or extend the window
   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (take) begin
         if (flush) begin
            cnt_in = '0;
         end else if (cnt_ff == '0) begin
            cnt_in = CNT_W'(1);
            sum_in = blm_pkg::SUM_W'(sample_mv);
            min_in = sample_mv;
            max_in = sample_mv;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            sum_in = sum_ff + blm_pkg::SUM_W'(sample_mv);
            if (sample_mv < min_ff) min_in = sample_mv;
            if (sample_mv > max_ff) max_in = sample_mv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Window data needs no reset: an empty window reloads it
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      min_ff <= min_in;
      max_ff <= max_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SAMPLES))
      else $error("sample count beyond window size");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> min_ff <= max_ff)
      else $error("window minimum above maximum");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      take && flush |=> cnt_ff == '0)
      else $error("window not restarted after flush");

endmodule

// ----- src/blm_charge.sv -----
// Filtered voltage, fault latch, low alert and charge level state.
module blm_charge (
   input  logic                       clock,
   input  logic                       reset,
   input  blm_pkg::blm_cfg_type       cfg,
   input  logic                       step_valid,
   input  blm_pkg::blm_step_type      step,
   output logic [blm_pkg::MV_W-1:0]   filtered_mv,
   output logic [1:0]                 level,
   output logic                       alert,
   output logic                       fault
);

   logic [blm_pkg::MV_W-1:0]   filt_ff, filt_in;
   blm_pkg::blm_level_type     level_ff, level_in;
   logic                       fault_ff, fault_in;
   logic                       alert_ff, alert_in;

   logic [blm_pkg::MV_W-1:0]        v;
   logic signed [blm_pkg::THR_W-1:0] v_s;
   logic signed [blm_pkg::THR_W-1:0] hyst_s;
   logic signed [blm_pkg::THR_W-1:0] thr_hi;
   logic signed [blm_pkg::THR_W-1:0] thr_lo;

   // Voltage seen by this request, after its averaging step
   assign v      = step.updated ? step.quot : filt_ff;
   assign v_s    = $signed({2'b00, v});
   assign hyst_s = $signed({5'b00000, cfg.hyst});
   assign thr_hi = step.thres + hyst_s;
   assign thr_lo = step.thres - hyst_s;

   // Fault latch with hysteresis; alert only while healthy
   always_comb begin
      filt_in  = filt_ff;
      fault_in = fault_ff;
      alert_in = alert_ff;
      if (step_valid) begin
         filt_in  = v;
         alert_in = 1'b0;
         if (v > cfg.fault_trip) begin
            if (fault_ff) begin
               if (v > cfg.fault_clear) fault_in = 1'b0;
            end else begin
               alert_in = (v <= step.mode_thr);
            end
         end else begin
            fault_in = 1'b1;
         end
      end
   end

   // Charge level around the fan-dependent threshold
   always_comb begin
      level_in = level_ff;
      if (step_valid) begin
         case (level_ff)
            blm_pkg::LEVEL_PLENTY: begin
               if (v_s < step.thres) level_in = blm_pkg::LEVEL_MID;
            end
            blm_pkg::LEVEL_MID: begin
               if (v_s > thr_hi) level_in = blm_pkg::LEVEL_PLENTY;
               if (v_s < thr_lo) level_in = blm_pkg::LEVEL_LOW;
            end
            blm_pkg::LEVEL_LOW: begin
               if (v_s > step.thres) level_in = blm_pkg::LEVEL_MID;
               if (v < cfg.very_low) level_in = blm_pkg::LEVEL_VERY_LOW;
            end
            blm_pkg::LEVEL_VERY_LOW: begin
               if (v_s > thr_lo) level_in = blm_pkg::LEVEL_LOW;
            end
            default: begin
               level_in = blm_pkg::LEVEL_PLENTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff  <= '0;
         level_ff <= blm_pkg::LEVEL_PLENTY;
         fault_ff <= 1'b0;
         alert_ff <= 1'b0;
      end else begin
         filt_ff  <= filt_in;
         level_ff <= level_in;
         fault_ff <= fault_in;
         alert_ff <= alert_in;
      end
   end

   assign filtered_mv = filt_ff;
   assign level       = level_ff;
   assign alert       = alert_ff;
   assign fault       = fault_ff;

   a_alert_healthy: assert property (@(posedge clock) disable iff (reset)
      alert_ff |-> !fault_ff)
      else $error("low alert raised with fault latched");

   a_plenty_step: assert property (@(posedge clock) disable iff (reset)
      level_ff == blm_pkg::LEVEL_PLENTY |=>
         level_ff == blm_pkg::LEVEL_PLENTY || level_ff == blm_pkg::LEVEL_MID)
      else $error("charge level skipped from plenty");

   a_very_low_step: assert property (@(posedge clock) disable iff (reset)
      level_ff == blm_pkg::LEVEL_VERY_LOW |=>
         level_ff == blm_pkg::LEVEL_VERY_LOW || level_ff == blm_pkg::LEVEL_LOW)
      else $error("charge level skipped from very low");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !step_valid |=> $stable(filt_ff) && $stable(fault_ff))
      else $error("state changed without a request");

endmodule

// ----- src/battery_level_monitor_core.sv -----
// Top level of the battery level monitor: config registers and three-stage request pipeline.
//
//  port group | direction | carries
//  req_*      | in        | sample_mv, fan_speed, mode_low_threshold_mv
//  rsp_*      | out       | cell_mv, charge_level, low_alert, battery_fault, average_updated
//  csr_*      | in        | register writes, index and 13-bit data
//
//  One request per cycle unless a stalled result holds the pipe.
//  Stage 1 updates the averaging window and forms the fan threshold product,
//  stage 2 runs the two reciprocal multipliers, stage 3 updates fault and level.
//  Reset clears the window, filtered voltage, fault latch and level, and loads
//  register defaults. A stalled result holds the pipe; empty stages still fill.
module battery_level_monitor_core #(
   parameter int SAMPLES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [blm_pkg::MV_W-1:0]        req_sample_mv,
   input  logic [blm_pkg::SPEED_W-1:0]     req_fan_speed,
   input  logic [blm_pkg::MV_W-1:0]        req_mode_low_threshold_mv,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [blm_pkg::MV_W-1:0]        rsp_cell_mv,
   output logic [1:0]                      rsp_charge_level,
   output logic                            rsp_low_alert,
   output logic                            rsp_battery_fault,
   output logic                            rsp_average_updated,
   input  logic                            csr_write_en,
   input  logic [blm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [blm_pkg::MV_W-1:0]        csr_wdata
);

   // Reciprocal for division by SAMPLES-2, exact over the sum range
   localparam int              DIV_D      = SAMPLES - 2;
   localparam int              DIV_SHIFT  = 27;
   localparam longint unsigned DIV_MUL_L  = ((64'd1 << DIV_SHIFT) + DIV_D - 1) / DIV_D;
   localparam logic [DIV_SHIFT:0] DIV_MUL = DIV_MUL_L[DIV_SHIFT:0];
   localparam int              AVG_PROD_W = blm_pkg::SUM_W + DIV_SHIFT + 1;

   blm_pkg::blm_cfg_type cfg_ff, cfg_in;

   logic adv1, adv2, adv3, take;

   logic                        avg_flush;
   logic [blm_pkg::SUM_W-1:0]   avg_rest;

   logic [blm_pkg::SPEED_W-1:0] speed_clamped;
   logic [blm_pkg::SPEED_W-1:0] speed_over;
   logic [blm_pkg::PROD_W-1:0]  prod_in;

   logic                        s1_valid_ff;
   logic                        s1_flush_ff;
   logic [blm_pkg::SUM_W-1:0]   s1_rest_ff;
   logic [blm_pkg::MV_W-1:0]    s1_mode_ff;
   logic [blm_pkg::PROD_W-1:0]  s1_prod_ff;

   logic [blm_pkg::DIV5_PROD_W-1:0] drop_prod;
   logic [blm_pkg::DROP_W-1:0]      drop;
   logic [AVG_PROD_W-1:0]           avg_prod;
   blm_pkg::blm_step_type           s2_in;

   logic                        s2_valid_ff;
   blm_pkg::blm_step_type       s2_ff;

   logic                        rsp_valid_ff;
   logic                        upd_ff;

   // Register writes; indexes beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            blm_pkg::CSR_FAULT_TRIP:  cfg_in.fault_trip  = csr_wdata;
            blm_pkg::CSR_FAULT_CLEAR: cfg_in.fault_clear = csr_wdata;
            blm_pkg::CSR_VERY_LOW:    cfg_in.very_low    = csr_wdata;
            blm_pkg::CSR_BASE_THR:    cfg_in.base_thr    = csr_wdata;
            blm_pkg::CSR_THR_SPAN:    cfg_in.thr_span    = csr_wdata[blm_pkg::SPAN_W-1:0];
            blm_pkg::CSR_HYST:        cfg_in.hyst        = csr_wdata[blm_pkg::SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= blm_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance each stage when it is empty or the one after moves
   assign adv3      = !rsp_valid_ff || !rsp_stall;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;
   assign take      = req_valid && adv1;

   blm_avg #(
      .SAMPLES (SAMPLES)
   ) u_avg (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .sample_mv (req_sample_mv),
      .flush     (avg_flush),
      .rest      (avg_rest)
   );

   // Fan threshold product: span * max(min(speed,100)-20, 0), rounded up for /80
   assign speed_clamped = (req_fan_speed > blm_pkg::SPEED_MAX) ? blm_pkg::SPEED_MAX
                                                                : req_fan_speed;
   assign speed_over    = (speed_clamped > blm_pkg::SPEED_KNEE)
                          ? speed_clamped - blm_pkg::SPEED_KNEE : '0;
   assign prod_in       = blm_pkg::PROD_W'(cfg_ff.thr_span) * blm_pkg::PROD_W'(speed_over)
                          + blm_pkg::DROP_ROUND;

   // Stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_flush_ff <= avg_flush;
         s1_rest_ff  <= avg_rest;
         s1_mode_ff  <= req_mode_low_threshold_mv;
         s1_prod_ff  <= prod_in;
      end
   end

   // Divide the threshold product by 80 and the trimmed sum by SAMPLES-2
   assign drop_prod = blm_pkg::DIV5_PROD_W'(s1_prod_ff[blm_pkg::PROD_W-1:blm_pkg::DIV16_SHIFT])
                      * blm_pkg::DIV5_PROD_W'(blm_pkg::DIV5_MUL);
   assign drop      = drop_prod[blm_pkg::DIV5_SHIFT +: blm_pkg::DROP_W];
   assign avg_prod  = AVG_PROD_W'(s1_rest_ff) * AVG_PROD_W'(DIV_MUL);

   always_comb begin
      s2_in.updated  = s1_flush_ff;
      s2_in.quot     = avg_prod[DIV_SHIFT +: blm_pkg::MV_W];
      s2_in.thres    = $signed({2'b00, cfg_ff.base_thr}) - $signed({5'b00000, drop});
      s2_in.mode_thr = s1_mode_ff;
   end

   // Stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   // Stage 3: decision state and result register
   blm_charge u_charge (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .step_valid  (s2_valid_ff && adv3),
      .step        (s2_ff),
      .filtered_mv (rsp_cell_mv),
      .level       (rsp_charge_level),
      .alert       (rsp_low_alert),
      .fault       (rsp_battery_fault)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         upd_ff <= s2_ff.updated;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_average_updated = upd_ff;

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff && !s2_valid_ff && !rsp_valid_ff |-> !req_stall)
      else $error("request stalled with an empty pipeline");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !adv3 |=> s2_valid_ff && $stable(s2_ff))
      else $error("stage 2 lost or changed a held request");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv2 |=> s1_valid_ff && $stable(s1_prod_ff) && $stable(s1_rest_ff))
      else $error("stage 1 lost or changed a held request");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled with room in the pipeline");

endmodule

// ----- bench/battery_level_monitor_core_test.sv -----
// Self-checking testbench for the battery level monitor core.
`timescale 1ns / 1ps

module battery_level_monitor_core_test;

   localparam int SAMPLES        = 8;
   localparam int PHASE_ITEMS    = 205;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 200;
   localparam int MAX_REPORTS    = 10;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int MV_TOP         = 8191;

   // Register indexes past the end of the list; writes to them are ignored
   localparam logic [blm_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [blm_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum {SET_RANDOM, SET_ALL_ONES, SET_ALL_ZEROS} setting_kind_type;

   typedef struct {
      logic [blm_pkg::MV_W-1:0]    sample;
      logic [blm_pkg::SPEED_W-1:0] speed;
      logic [blm_pkg::MV_W-1:0]    mode_thr;
   } sample_req_type;

   typedef struct packed {
      logic [blm_pkg::MV_W-1:0] cell_mv;
      blm_pkg::blm_level_type   level;
      logic                     low_alert;
      logic                     battery_fault;
      logic                     average_updated;
   } reading_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [blm_pkg::MV_W-1:0]      req_sample_mv = '0;
   logic [blm_pkg::SPEED_W-1:0]   req_fan_speed = '0;
   logic [blm_pkg::MV_W-1:0]      req_mode_low_threshold_mv = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [blm_pkg::MV_W-1:0]      rsp_cell_mv;
   logic [1:0]                    rsp_charge_level;
   logic                          rsp_low_alert;
   logic                          rsp_battery_fault;
   logic                          rsp_average_updated;
   logic                          csr_write_en = 1'b0;
   logic [blm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [blm_pkg::MV_W-1:0]      csr_wdata = '0;

   sample_req_type pending_reqs[$];
   reading_type    expected_readings[$];
   logic           req_took = 1'b0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   logic           hold_armed = 1'b0;
   int             hold_count = 0;
   int             mismatches = 0;

   // Monitor's own copy of the block state and registers
   blm_pkg::blm_cfg_type      model_cfg;
   logic [blm_pkg::SUM_W-1:0] acc_sum;
   int                        acc_min;
   int                        acc_max;
   int                        acc_count;
   logic [blm_pkg::MV_W-1:0]  model_filtered;
   blm_pkg::blm_level_type    model_level;
   logic                      model_fault;

   battery_level_monitor_core #(.SAMPLES(SAMPLES)) u_dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_sample_mv             (req_sample_mv),
      .req_fan_speed             (req_fan_speed),
      .req_mode_low_threshold_mv (req_mode_low_threshold_mv),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_cell_mv               (rsp_cell_mv),
      .rsp_charge_level          (rsp_charge_level),
      .rsp_low_alert             (rsp_low_alert),
      .rsp_battery_fault         (rsp_battery_fault),
      .rsp_average_updated       (rsp_average_updated),
      .csr_write_en              (csr_write_en),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic void clear_window();
      acc_sum   = '0;
      acc_min   = 32766;
      acc_max   = -32766;
      acc_count = 0;
   endfunction

   function automatic void apply_register(logic [blm_pkg::CSR_IDX_W-1:0] idx,
                                          logic [blm_pkg::MV_W-1:0] data);
      case (idx)
         blm_pkg::CSR_FAULT_TRIP:  model_cfg.fault_trip  = data;
         blm_pkg::CSR_FAULT_CLEAR: model_cfg.fault_clear = data;
         blm_pkg::CSR_VERY_LOW:    model_cfg.very_low    = data;
         blm_pkg::CSR_BASE_THR:    model_cfg.base_thr    = data;
         blm_pkg::CSR_THR_SPAN:    model_cfg.thr_span    = data[blm_pkg::SPAN_W-1:0];
         blm_pkg::CSR_HYST:        model_cfg.hyst        = data[blm_pkg::SPAN_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the monitor state by one request and return the reading it yields
   function automatic reading_type predict_reading(sample_req_type r);
      reading_type res;
      int smp, v, rest, d, drop, thres, hyst, speed;
      smp = int'(r.sample);
      res.average_updated = 1'b0;
      res.low_alert = 1'b0;

      // averaging window: collect, or drop this sample and publish
      if (acc_count < SAMPLES) begin
         acc_sum = acc_sum + blm_pkg::SUM_W'(smp);
         acc_count++;
         if (acc_min > smp) acc_min = smp;
         if (acc_max < smp) acc_max = smp;
      end else begin
         rest = int'(acc_sum) - acc_min - acc_max;
         if (rest < 0) rest = 0;
         rest = rest / (SAMPLES - 2);
         if (rest > MV_TOP) rest = MV_TOP;
         model_filtered = blm_pkg::MV_W'(rest);
         clear_window();
         res.average_updated = 1'b1;
      end
      v = int'(model_filtered);

      // fault latch with hysteresis, alert only while no fault
      if (v > int'(model_cfg.fault_trip)) begin
         if (model_fault) begin
            if (v > int'(model_cfg.fault_clear)) model_fault = 1'b0;
         end else begin
            res.low_alert = (v <= int'(r.mode_thr));
         end
      end else begin
         model_fault = 1'b1;
      end

      // fan-dependent threshold, speed clamped to 100 percent
      speed = int'(r.speed);
      if (speed > 100) speed = 100;
      d = speed - 20;
      if (d < 0) d = 0;
      drop = (int'(model_cfg.thr_span) * d + 79) / 80;
      thres = int'(model_cfg.base_thr) - drop;
      hyst = int'(model_cfg.hyst);

      case (model_level)
         blm_pkg::LEVEL_PLENTY: begin
            if (v < thres) model_level = blm_pkg::LEVEL_MID;
         end
         blm_pkg::LEVEL_MID: begin
            if (v > thres + hyst) model_level = blm_pkg::LEVEL_PLENTY;
            if (v < thres - hyst) model_level = blm_pkg::LEVEL_LOW;
         end
         blm_pkg::LEVEL_LOW: begin
            if (v > thres) model_level = blm_pkg::LEVEL_MID;
            if (v < int'(model_cfg.very_low)) model_level = blm_pkg::LEVEL_VERY_LOW;
         end
         default: begin
            if (v > thres - hyst) model_level = blm_pkg::LEVEL_LOW;
         end
      endcase

      res.cell_mv = model_filtered;
      res.level = model_level;
      res.battery_fault = model_fault;
      return res;
   endfunction

   function automatic void note_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
   endfunction

   // ---------------------------------------------------------------- monitor

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin : watch_ports
      sample_req_type taken;
      reading_type want;
      req_took <= !reset && req_valid && !req_stall;
      if (reset) begin
         model_cfg = blm_pkg::CFG_RESET;
         clear_window();
         model_filtered = '0;
         model_level = blm_pkg::LEVEL_PLENTY;
         model_fault = 1'b0;
      end else begin
         if (csr_write_en) apply_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            taken.sample = req_sample_mv;
            taken.speed = req_fan_speed;
            taken.mode_thr = req_mode_low_threshold_mv;
            expected_readings.push_back(predict_reading(taken));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               note_mismatch("reading with none pending, cell_mv", 0, rsp_cell_mv);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_cell_mv !== want.cell_mv)
                  note_mismatch("cell_mv", want.cell_mv, rsp_cell_mv);
               if (rsp_charge_level !== want.level)
                  note_mismatch("charge_level", want.level, rsp_charge_level);
               if (rsp_low_alert !== want.low_alert)
                  note_mismatch("low_alert", want.low_alert, rsp_low_alert);
               if (rsp_battery_fault !== want.battery_fault)
                  note_mismatch("battery_fault", want.battery_fault, rsp_battery_fault);
               if (rsp_average_updated !== want.average_updated)
                  note_mismatch("average_updated", want.average_updated,
                                rsp_average_updated);
            end
         end
      end
   end

   // ---------------------------------------------------------------- driver

   // Offer the next request once the current one has been taken
   always @(negedge clock) begin : drive_requests
      sample_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_took || !req_valid) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_sample_mv <= next_req.sample;
            req_fan_speed <= next_req.speed;
            req_mode_low_threshold_mv <= next_req.mode_thr;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall results at random; once armed, hold off for one long stretch
   always @(negedge clock) begin
      if (hold_armed && hold_count < LONG_HOLD) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [blm_pkg::MV_W-1:0] clamp_mv(int x);
      if (x < 0) return '0;
      if (x > MV_TOP) return blm_pkg::MV_W'(MV_TOP);
      return blm_pkg::MV_W'(x);
   endfunction

   function automatic logic [blm_pkg::SPEED_W-1:0] pick_speed();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return blm_pkg::SPEED_W'($urandom_range(101, 127));
      if (roll < 35) return blm_pkg::SPEED_W'($urandom_range(0, 20));
      return blm_pkg::SPEED_W'($urandom_range(21, 100));
   endfunction

   // Aim the next window near a decision point, walk from the last one, or pick one at random
   function automatic int pick_target(int last);
      int t;
      case ($urandom_range(0, 6))
         0, 1: t = last + int'($urandom_range(0, 300)) - 150;
         2: t = int'(model_cfg.fault_trip);
         3: t = int'(model_cfg.fault_clear);
         4: t = int'(model_cfg.very_low);
         5: t = int'(model_cfg.base_thr) - int'($urandom_range(0, model_cfg.thr_span))
                + int'($urandom_range(0, 2 * model_cfg.hyst)) - int'(model_cfg.hyst);
         default: t = int'($urandom_range(0, MV_TOP));
      endcase
      return int'(clamp_mv(t + int'($urandom_range(0, 80)) - 40));
   endfunction

   task automatic push_req(int sample, int speed, int mode_thr);
      sample_req_type r;
      r.sample = blm_pkg::MV_W'(sample);
      r.speed = blm_pkg::SPEED_W'(speed);
      r.mode_thr = blm_pkg::MV_W'(mode_thr);
      pending_reqs.push_back(r);
   endtask

   // One full window around a target, sometimes with a wild sample in it
   task automatic queue_window(int target);
      int spread, odd_slot;
      sample_req_type r;
      spread = $urandom_range(0, 60);
      odd_slot = $urandom_range(0, 2 * SAMPLES);
      for (int i = 0; i <= SAMPLES; i++) begin
         if (i == odd_slot) r.sample = blm_pkg::MV_W'($urandom);
         else r.sample = clamp_mv(target + int'($urandom_range(0, 2 * spread)) - spread);
         r.speed = pick_speed();
         r.mode_thr = clamp_mv(target + int'($urandom_range(0, 200)) - 100);
         pending_reqs.push_back(r);
      end
   endtask

   // Mostly well-formed windows, the rest bursts of noise that shift alignment
   task automatic queue_phase(int count);
      int queued, target, burst;
      queued = 0;
      target = int'(model_cfg.base_thr);
      while (queued < count) begin
         if ($urandom_range(0, 9) < 8) begin
            target = pick_target(target);
            queue_window(target);
            queued += SAMPLES + 1;
         end else begin
            burst = $urandom_range(1, 12);
            repeat (burst)
               push_req($urandom_range(0, MV_TOP), $urandom_range(0, 127),
                        $urandom_range(0, MV_TOP));
            queued += burst;
         end
      end
   endtask

   task automatic write_register(logic [blm_pkg::CSR_IDX_W-1:0] idx,
                                 logic [blm_pkg::MV_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic load_settings(setting_kind_type kind);
      logic [blm_pkg::MV_W-1:0] fill, trip;
      case (kind)
         SET_RANDOM: begin
            trip = blm_pkg::MV_W'($urandom_range(2400, 3100));
            write_register(blm_pkg::CSR_FAULT_TRIP, trip);
            write_register(blm_pkg::CSR_FAULT_CLEAR,
                           trip + blm_pkg::MV_W'($urandom_range(0, 400)));
            write_register(blm_pkg::CSR_VERY_LOW, blm_pkg::MV_W'($urandom_range(2500, 3300)));
            write_register(blm_pkg::CSR_BASE_THR, blm_pkg::MV_W'($urandom_range(3000, 4500)));
            // upper bits of the narrow registers are junk and must be dropped
            write_register(blm_pkg::CSR_THR_SPAN, {3'($urandom), 10'($urandom)});
            write_register(blm_pkg::CSR_HYST, {3'($urandom), 10'($urandom_range(0, 400))});
         end
         default: begin
            fill = (kind == SET_ALL_ONES) ? '1 : '0;
            write_register(blm_pkg::CSR_FAULT_TRIP, fill);
            write_register(blm_pkg::CSR_FAULT_CLEAR, fill);
            write_register(blm_pkg::CSR_VERY_LOW, fill);
            write_register(blm_pkg::CSR_BASE_THR, fill);
            write_register(blm_pkg::CSR_THR_SPAN, fill);
            write_register(blm_pkg::CSR_HYST, fill);
         end
      endcase
      write_register(CSR_SPARE_LO, blm_pkg::MV_W'($urandom));
      write_register(CSR_SPARE_HI, blm_pkg::MV_W'($urandom));
   endtask

   // Wait for every request to be taken and answered, then let the pipe drain
   task automatic settle();
      while (pending_reqs.size() != 0 || req_valid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 13;
      recv_idle_pct = 62;

      // field extremes and the fan clamp edges, one window
      push_req(0, 0, 0);
      push_req(MV_TOP, 127, MV_TOP);
      push_req(4000, 20, 4000);
      push_req(4000, 21, 0);
      push_req(4000, 100, MV_TOP);
      push_req(4000, 101, 4000);
      push_req(MV_TOP, 99, 1);
      push_req(0, 1, 8190);
      push_req(4000, 64, 4000);
      // a window below the trip level latches the fault
      repeat (SAMPLES + 1) push_req(2700, 0, MV_TOP);
      // a partial window well above everything
      repeat (SAMPLES - 1) push_req(5000, 127, 5000);
      queue_phase(PHASE_ITEMS);
      settle();

      load_settings(SET_RANDOM);
      queue_phase(PHASE_ITEMS);
      settle();

      // sender idles heavily, receiver lightly
      send_idle_pct = 62;
      recv_idle_pct = 13;
      load_settings(SET_ALL_ONES);
      queue_phase(PHASE_ITEMS);
      settle();

      load_settings(SET_ALL_ZEROS);
      queue_phase(PHASE_ITEMS);
      settle();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings(SET_RANDOM);
      queue_phase(PHASE_ITEMS);
      settle();

      // long result hold-off while requests keep coming
      load_settings(SET_RANDOM);
      hold_armed = 1'b1;
      queue_phase(PHASE_ITEMS);
      settle();

      if (mismatches == 0) begin
         $display("battery_level_monitor_core_test passed");
      end else begin
         $display("battery_level_monitor_core_test failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2);
      $display("battery_level_monitor_core_test failed");
      $finish;
   end

endmodule
